>>> hw/rtl/lbs_pkg.sv
// Shared constants, item and configuration types, and RGB565 packing helpers
// for the letterbox scaler. No dependencies.
`timescale 1ns / 1ps

package lbs_pkg;

  // Source frame geometry (square NV12 frame, power-of-two side)
  localparam int SRC_DIM      = 128;
  localparam int SRC_AW       = $clog2(SRC_DIM);
  localparam int LUMA_BYTES   = SRC_DIM * SRC_DIM;
  localparam int LUMA_AW      = 2 * SRC_AW;
  localparam int STORE_BYTES  = LUMA_BYTES + LUMA_BYTES / 2;
  localparam int CHROMA_WORDS = LUMA_BYTES / 4;
  localparam int CHROMA_AW    = LUMA_AW - 2;
  localparam int ADDR_W       = 15;

  // Display geometry and fixed-point scale factor
  localparam int MAX_DISP_DIM = 4096;
  localparam int DIM_W        = $clog2(MAX_DISP_DIM);
  localparam int FRAC_W       = 16;
  localparam int INV_W        = SRC_AW + FRAC_W + 1;
  localparam int PROD_W       = DIM_W + INV_W;
  localparam logic [INV_W-1:0] RECIP_NUM = INV_W'(SRC_DIM) << FRAC_W;

  // Request queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  // Render modes (any other code renders as YUV colour)
  localparam logic [1:0] MODE_YUV  = 2'd0;
  localparam logic [1:0] MODE_GRAY = 2'd1;
  localparam logic [1:0] MODE_FLOW = 2'd2;

  localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(1080);

  typedef struct packed {
    logic               pix;   // 1: pixel request, 0: source byte write
    logic               win;   // pixel inside the centered square
    logic [ADDR_W-1:0]  addr;
    logic [7:0]         data;
    logic [DIM_W-1:0]   ox;    // column offset inside the square
    logic [DIM_W-1:0]   oy;    // row offset inside the square
  } lbs_item_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [INV_W-1:0] inv;
  } lbs_cfg_t;

  function automatic logic [15:0] gray565(input logic [7:0] y8);
    return {y8[7:3], y8[7:2], y8[7:3]};
  endfunction

  function automatic logic [15:0] flow565(input logic [7:0] code);
    logic [15:0] res;
    case (code)
      8'd0:    res = 16'h0000;
      8'd50:   res = 16'hf800;
      8'd100:  res = 16'h07ff;
      8'd150:  res = 16'h07e0;
      8'd200:  res = 16'hf81f;
      default: res = gray565(code);
    endcase
    return res;
  endfunction

endpackage

>>> hw/rtl/lbs_recip.sv
// Restoring divider: one quotient bit per cycle for the fixed-point ratio of the
// source side to the square side. Depends on lbs_pkg.
`timescale 1ns / 1ps

module lbs_recip (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lbs_pkg::DIM_W-1:0]    divisor,
  output logic                         run,
  output logic [lbs_pkg::INV_W-1:0]    quot
);

  localparam int CNT_W = $clog2(lbs_pkg::INV_W);

  logic [CNT_W-1:0]            cnt;
  logic [lbs_pkg::DIM_W-1:0]   rem;
  logic [lbs_pkg::DIM_W-1:0]   rem_next;
  logic [lbs_pkg::INV_W-1:0]   num;
  logic [lbs_pkg::DIM_W:0]     trial;
  logic                        ge;

  assign trial    = {rem, num[lbs_pkg::INV_W-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign rem_next = ge ? lbs_pkg::DIM_W'(trial - {1'b0, divisor})
                       : trial[lbs_pkg::DIM_W-1:0];
  assign quot     = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= CNT_W'(lbs_pkg::INV_W - 1);
    end else if (run) begin
      if (cnt == '0) begin
        run <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      num <= lbs_pkg::RECIP_NUM;
    end else if (run) begin
      rem <= rem_next;
      num <= {num[lbs_pkg::INV_W-2:0], ge};
    end
  end

endmodule

>>> hw/rtl/lbs_front.sv
// Front end: configuration registers, window geometry recalculation and
// request classification into queue entries. Depends on lbs_pkg, lbs_recip.
`timescale 1ns / 1ps

module lbs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [lbs_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [lbs_pkg::ADDR_W-1:0]    src_addr,
  input  logic [7:0]                    src_byte,
  input  logic [lbs_pkg::DIM_W-1:0]     pix_x,
  input  logic [lbs_pkg::DIM_W-1:0]     pix_y,
  output logic                          push,
  output lbs_pkg::lbs_item_t            item,
  input  logic                          full,
  output lbs_pkg::lbs_cfg_t             cfg
);

  typedef enum logic [3:0] {
    RC_IDLE   = 4'b0001,
    RC_SQUARE = 4'b0010,
    RC_EDGES  = 4'b0100,
    RC_DIV    = 4'b1000
  } rc_state_t;

  rc_state_t                   state;
  logic [lbs_pkg::DIM_W-1:0]   disp_w;
  logic [lbs_pkg::DIM_W-1:0]   disp_h;
  logic [1:0]                  mode;
  logic [lbs_pkg::DIM_W-1:0]   square;
  logic [lbs_pkg::DIM_W-1:0]   x0;
  logic [lbs_pkg::DIM_W-1:0]   x1;
  logic [lbs_pkg::DIM_W-1:0]   y0;
  logic [lbs_pkg::DIM_W-1:0]   y1;
  logic [lbs_pkg::DIM_W-1:0]   x0_next;
  logic [lbs_pkg::DIM_W-1:0]   y0_next;
  logic                        f_vld;
  lbs_pkg::lbs_item_t          f_item;
  lbs_pkg::lbs_item_t          f_item_next;
  logic                        div_run;
  logic [lbs_pkg::INV_W-1:0]   inv;
  logic                        accept;

  lbs_recip u_recip (
    .clk     (clk),
    .rst     (rst),
    .start   (state == RC_EDGES),
    .divisor (square),
    .run     (div_run),
    .quot    (inv)
  );

  assign x0_next = (disp_w - square) >> 1;
  assign y0_next = (disp_h - square) >> 1;

  // Configuration registers and geometry recalculation
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_w <= lbs_pkg::RST_WIDTH;
      disp_h <= lbs_pkg::RST_HEIGHT;
      mode   <= lbs_pkg::MODE_YUV;
      state  <= RC_SQUARE;
    end else if (cfg_we) begin
      case (cfg_index)
        lbs_pkg::REG_WIDTH:  disp_w <= cfg_data;
        lbs_pkg::REG_HEIGHT: disp_h <= cfg_data;
        lbs_pkg::REG_MODE:   mode   <= cfg_data[1:0];
        default:             ;
      endcase
      state <= RC_SQUARE;
    end else begin
      case (state)
        RC_SQUARE: state <= RC_EDGES;
        RC_EDGES:  state <= RC_DIV;
        RC_DIV:    if (!div_run) state <= RC_IDLE;
        default:   state <= RC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == RC_SQUARE) begin
      square <= (disp_w < disp_h) ? disp_w : disp_h;
    end
    if (state == RC_EDGES) begin
      x0 <= x0_next;
      x1 <= x0_next + square;
      y0 <= y0_next;
      y1 <= y0_next + square;
    end
  end

  // Classify the incoming request
  always_comb begin
    f_item_next.pix  = req_type;
    f_item_next.win  = (pix_x >= x0) && (pix_x < x1) && (pix_y >= y0) && (pix_y < y1);
    f_item_next.addr = src_addr;
    f_item_next.data = src_byte;
    f_item_next.ox   = pix_x - x0;
    f_item_next.oy   = pix_y - y0;
  end

  assign push     = f_vld && !full;
  assign in_ready = (state == RC_IDLE) && (!f_vld || !full);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (accept) begin
      f_vld <= 1'b1;
    end else if (push) begin
      f_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= f_item_next;
    end
  end

  assign item     = f_item;
  assign cfg.mode = mode;
  assign cfg.inv  = inv;

endmodule

>>> hw/rtl/lbs_fifo.sv
// Short request queue between front and back end. Depends on lbs_pkg.
`timescale 1ns / 1ps

module lbs_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lbs_pkg::lbs_item_t  din,
  input  logic                pop,
  output lbs_pkg::lbs_item_t  dout,
  output logic                empty,
  output logic                full
);

  lbs_pkg::lbs_item_t            entries [lbs_pkg::FIFO_DEPTH];
  logic [lbs_pkg::FIFO_PW-1:0]   wr_ptr;
  logic [lbs_pkg::FIFO_PW-1:0]   rd_ptr;
  logic [lbs_pkg::FIFO_CW-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == lbs_pkg::FIFO_CW'(lbs_pkg::FIFO_DEPTH));
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

>>> hw/rtl/lbs_back.sv
// Back end: source scaling, frame store (luma, U, V memories), colour
// conversion and output register. Depends on lbs_pkg.
`timescale 1ns / 1ps

module lbs_back (
  input  logic                clk,
  input  logic                rst,
  input  lbs_pkg::lbs_cfg_t   cfg,
  input  lbs_pkg::lbs_item_t  head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         pixel_rgb565,
  output logic                in_window
);

  localparam int PW = lbs_pkg::PROD_W;
  localparam int SW = lbs_pkg::SRC_AW;

  logic [7:0] luma_mem [lbs_pkg::LUMA_BYTES];
  logic [7:0] u_mem    [lbs_pkg::CHROMA_WORDS];
  logic [7:0] v_mem    [lbs_pkg::CHROMA_WORDS];

  logic                          adv;

  // Stage 1: scale products
  logic                          s1_vld;
  logic                          s1_pix;
  logic                          s1_win;
  logic [lbs_pkg::ADDR_W-1:0]    s1_addr;
  logic [7:0]                    s1_data;
  logic [PW-1:0]                 s1_px;
  logic [PW-1:0]                 s1_py;

  // Stage 2: source bytes
  logic                          s2_vld;
  logic                          s2_win;
  logic [7:0]                    s2_y;
  logic [7:0]                    s2_u;
  logic [7:0]                    s2_v;

  // Stage 3: colour products
  logic                          s3_vld;
  logic                          s3_win;
  logic [7:0]                    s3_y;
  logic signed [17:0]            s3_rp;
  logic signed [17:0]            s3_gp;
  logic signed [17:0]            s3_bp;

  logic [SW-1:0]                 sx;
  logic [SW-1:0]                 sy;
  logic [lbs_pkg::ADDR_W-1:0]    chroma_off;
  logic                          wr_luma;
  logic                          wr_chroma;
  logic signed [17:0]            u_s;
  logic signed [17:0]            v_s;
  logic signed [17:0]            r_sum;
  logic signed [17:0]            g_sum;
  logic signed [17:0]            b_sum;
  logic [7:0]                    r8;
  logic [7:0]                    g8;
  logic [7:0]                    b8;
  logic [15:0]                   pix_next;

  function automatic logic [SW-1:0] clamp_src(input logic [PW-1:0] prod);
    logic [PW-lbs_pkg::FRAC_W-1:0] s;
    s = prod[PW-1:lbs_pkg::FRAC_W];
    if (s > (PW-lbs_pkg::FRAC_W)'(lbs_pkg::SRC_DIM - 1)) begin
      return SW'(lbs_pkg::SRC_DIM - 1);
    end
    return s[SW-1:0];
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [17:0] x);
    if (x < 0) return 8'd0;
    if (x > 18'sd255) return 8'd255;
    return x[7:0];
  endfunction

  // The whole back pipeline moves together, held only by the output register
  assign adv = !out_valid || out_ready;
  assign pop = adv && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      s3_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_vld    <= !empty;
      s2_vld    <= s1_vld && s1_pix;
      s3_vld    <= s2_vld;
      out_valid <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix  <= head.pix;
      s1_win  <= head.win;
      s1_addr <= head.addr;
      s1_data <= head.data;
      s1_px   <= PW'(head.ox) * PW'(cfg.inv);
      s1_py   <= PW'(head.oy) * PW'(cfg.inv);
    end
  end

  // Frame store access: byte writes and pixel reads in the same stage keep order
  assign sx         = clamp_src(s1_px);
  assign sy         = clamp_src(s1_py);
  assign chroma_off = s1_addr - lbs_pkg::ADDR_W'(lbs_pkg::LUMA_BYTES);
  assign wr_luma    = s1_vld && !s1_pix
                      && (s1_addr < lbs_pkg::ADDR_W'(lbs_pkg::LUMA_BYTES));
  assign wr_chroma  = s1_vld && !s1_pix
                      && (s1_addr >= lbs_pkg::ADDR_W'(lbs_pkg::LUMA_BYTES))
                      && (s1_addr < lbs_pkg::ADDR_W'(lbs_pkg::STORE_BYTES));

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_luma) begin
        luma_mem[s1_addr[lbs_pkg::LUMA_AW-1:0]] <= s1_data;
      end
      if (wr_chroma && !chroma_off[0]) begin
        u_mem[chroma_off[lbs_pkg::CHROMA_AW:1]] <= s1_data;
      end
      if (wr_chroma && chroma_off[0]) begin
        v_mem[chroma_off[lbs_pkg::CHROMA_AW:1]] <= s1_data;
      end
      s2_y   <= luma_mem[{sy, sx}];
      s2_u   <= u_mem[{sy[SW-1:1], sx[SW-1:1]}];
      s2_v   <= v_mem[{sy[SW-1:1], sx[SW-1:1]}];
      s2_win <= s1_win;
    end
  end

  // BT.601 products
  assign u_s = $signed({10'd0, s2_u}) - 18'sd128;
  assign v_s = $signed({10'd0, s2_v}) - 18'sd128;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_win <= s2_win;
      s3_y   <= s2_y;
      s3_rp  <= 18'(v_s * 18'sd359);
      s3_gp  <= 18'(u_s * 18'sd88) + 18'(v_s * 18'sd183);
      s3_bp  <= 18'(u_s * 18'sd454);
    end
  end

  // Floor shift, clamp and pack
  assign r_sum = $signed({10'd0, s3_y}) + (s3_rp >>> 8);
  assign g_sum = $signed({10'd0, s3_y}) - (s3_gp >>> 8);
  assign b_sum = $signed({10'd0, s3_y}) + (s3_bp >>> 8);
  assign r8    = clamp8(r_sum);
  assign g8    = clamp8(g_sum);
  assign b8    = clamp8(b_sum);

  always_comb begin
    case (cfg.mode)
      lbs_pkg::MODE_GRAY: pix_next = lbs_pkg::gray565(s3_y);
      lbs_pkg::MODE_FLOW: pix_next = lbs_pkg::flow565(s3_y);
      default:            pix_next = {r8[7:3], g8[7:2], b8[7:3]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_rgb565 <= s3_win ? pix_next : 16'h0000;
      in_window    <= s3_win;
    end
  end

endmodule

>>> hw/rtl/letterbox_scaler_yuv_to_rgb565.sv
// NV12 to RGB565 letterbox scaler, top level. Depends on lbs_pkg and the lbs_* modules.
// Throughput: one request per cycle unless the queue is full or the geometry is being rebuilt.
// Rate is set by the back pipeline (scale multiply, frame store read, colour math, out reg).
// After reset and after every configuration write, requests are held off while the square side and
// window edges are rebuilt and the divider forms the scale inverse.
// Reset is synchronous, active high; the frame store is not cleared.
`timescale 1ns / 1ps

module letterbox_scaler_yuv_to_rgb565 (
  input  logic         clk,
  input  logic         rst,
  // configuration write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [11:0]  cfg_data,
  // request channel
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         req_type,
  input  logic [14:0]  src_addr,
  input  logic [7:0]   src_byte,
  input  logic [11:0]  pix_x,
  input  logic [11:0]  pix_y,
  // result channel
  output logic         out_valid,
  input  logic         out_ready,
  output logic [15:0]  pixel_rgb565,
  output logic         in_window
);

  // Front side: a request is classified (byte write or pixel, inside the square
  // or not, offset into the square) and parked in the front register.
  lbs_pkg::lbs_item_t  f_item;
  lbs_pkg::lbs_item_t  q_head;
  lbs_pkg::lbs_cfg_t   cfg;
  logic                f_push;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;

  lbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .src_addr  (src_addr),
    .src_byte  (src_byte),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .push      (f_push),
    .item      (f_item),
    .full      (q_full),
    .cfg       (cfg)
  );

  // Queue: absorbs stalls from the result side so the front keeps taking requests until it fills
  lbs_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_item),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  // Back side: byte writes land in the frame store in request order; pixel
  // requests scale, read Y/U/V, convert and drive the output register.
  lbs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (q_head),
    .empty        (q_empty),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_rgb565 (pixel_rgb565),
    .in_window    (in_window)
  );

endmodule
